/* rtl/core/rwph_pkg.sv */
// Shared constants, register indexes and unit command types for the rolling window hash.
`timescale 1ns / 1ps
`default_nettype none

package rwph_pkg;

   localparam int MAX_WINDOW = 64;

   localparam int SYM_W     = 64;
   localparam int HASH_W    = 31;
   localparam int CSR_W     = 31;
   localparam int LEN_W     = 7;
   localparam int STEP_W    = 7;
   localparam int REG_IDX_W = 2;

   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int POS_W  = FILL_W + 1;

   localparam logic [REG_IDX_W-1:0] REG_MODULUS       = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BASE          = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_BYTE_MODE     = 2'd3;

   localparam logic [HASH_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;
   localparam logic [HASH_W-1:0] BASE_RESET    = 31'd256;
   localparam logic [LEN_W-1:0]  LENGTH_RESET  = 7'd16;

   localparam logic [HASH_W-1:0] MODULUS_MIN = 31'd2;
   localparam logic [HASH_W-1:0] ONE         = 31'd1;

   localparam logic [7:0] BYTE_OFFSET = 8'h80;

   localparam logic [STEP_W-1:0] STEPS_WORD   = 7'd64;
   localparam logic [STEP_W-1:0] STEPS_BYTE   = 7'd8;
   localparam logic [STEP_W-1:0] STEPS_RESIDUE = 7'd31;
   localparam logic [STEP_W-1:0] STEPS_NONE   = 7'd0;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] multiplicand;
      logic [SYM_W-1:0]  digits;
      logic [STEP_W-1:0] steps;
   } mm_cmd_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] result;
   } mm_sts_type;

endpackage

`default_nettype wire

/* rtl/core/rwph_req_if.sv */
// Input channel: one symbol beat with its restart flag.
`timescale 1ns / 1ps
`default_nettype none

interface rwph_req_if import rwph_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             restart;

   modport source (output valid, output symbol, output restart, input ready);
   modport sink (input valid, input symbol, input restart, output ready);
endinterface

`default_nettype wire

/* rtl/core/rwph_rsp_if.sv */
// Result channel: one hash beat with its window-full flag.
`timescale 1ns / 1ps
`default_nettype none

interface rwph_rsp_if import rwph_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] hash_value;
   logic              window_full;

   modport source (output valid, output hash_value, output window_full, input ready);
   modport sink (input valid, input hash_value, input window_full, output ready);
endinterface

`default_nettype wire

/* rtl/core/rwph_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module rwph_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/rwph_modmul.sv */
// Bit-serial modular multiply-reduce unit: one multiplier digit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rwph_modmul import rwph_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mm_cmd_type        cmd,
   input  wire logic [HASH_W-1:0] modulus,
   output mm_sts_type             sts
);

   logic [HASH_W-1:0] acc_ff, acc_in;
   logic [HASH_W-1:0] mult_ff, mult_in;
   logic [SYM_W-1:0]  digits_ff, digits_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [HASH_W+1:0] sum;
   logic [HASH_W+1:0] sum_less_p;
   logic [HASH_W+1:0] sum_less_2p;
   logic [HASH_W+1:0] p_one;
   logic [HASH_W+1:0] p_two;
   logic [HASH_W-1:0] reduced;

   always_comb begin
      p_one       = {2'b00, modulus};
      p_two       = {1'b0, modulus, 1'b0};
      sum         = {1'b0, acc_ff, 1'b0}
                  + (digits_ff[SYM_W-1] ? {2'b00, mult_ff} : '0);
      sum_less_p  = sum - p_one;
      sum_less_2p = sum - p_two;
      if (sum >= p_two) begin
         reduced = sum_less_2p[HASH_W-1:0];
      end else if (sum >= p_one) begin
         reduced = sum_less_p[HASH_W-1:0];
      end else begin
         reduced = sum[HASH_W-1:0];
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      mult_in   = mult_ff;
      digits_in = digits_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         mult_in   = cmd.multiplicand;
         digits_in = cmd.digits;
         count_in  = cmd.steps;
         if (cmd.steps == STEPS_NONE) begin
            acc_in  = cmd.multiplicand;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         acc_in    = reduced;
         digits_in = {digits_ff[SYM_W-2:0], 1'b0};
         count_in  = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mult_ff   <= mult_in;
      digits_ff <= digits_in;
      count_ff  <= count_in;
   end

   assign sts = '{done: done_ff, result: acc_ff};

endmodule

`default_nettype wire

/* rtl/core/rolling_window_polynomial_hash.sv */
// Rolling window polynomial hash top level: sequencer, window store and result register.
// Keeps a polynomial hash modulo a programmable modulus over the last window_length symbols.
// One symbol is taken at a time; its hash beat comes out on the result channel. Every modular
// product runs through one bit-serial multiply-reduce unit, one multiplier bit per cycle, and
// the first symbol of a window skips the leading-power steps. A finished item may wait for the
// result register to drain. The next symbol is taken while a result still waits. The user
// must write registers through the csr port only while idle; the block does not enforce it.
// A window_length of zero acts as one, above the window store depth it saturates.
`timescale 1ns / 1ps
`default_nettype none

module rolling_window_polynomial_hash import rwph_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rwph_req_if.sink                  req_bus,
   rwph_rsp_if.source                rsp_bus,
   input  wire logic                 csr_wr_en,
   input  wire logic [REG_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PH_SYMBOL,
      PH_LEAD_RED,
      PH_LEAD_MUL,
      PH_TERM,
      PH_HASH_RED,
      PH_HASH_MUL
   } phase_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;

   logic [HASH_W-1:0] modulus_ff, modulus_in;
   logic [HASH_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  wlen_ff, wlen_in;
   logic              byte_mode_ff, byte_mode_in;

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] lead_ff, lead_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              roll_ff, roll_in;

   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [HASH_W-1:0] resid_ff, resid_in;
   logic [HASH_W-1:0] opa_ff, opa_in;
   logic [HASH_W-1:0] term_ff, term_in;
   logic [HASH_W-1:0] prod_ff, prod_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic              rsp_full_ff, rsp_full_in;

   logic [HASH_W-1:0] p_eff;
   logic [FILL_W-1:0] len_eff;
   logic [FILL_W-1:0] fill_cur;
   logic [FILL_W-1:0] fill_next;
   logic [POS_W-1:0]  pos_sum;
   logic [POS_W-1:0]  pos_wrap;
   logic [PTR_W-1:0]  wr_pos;
   logic [PTR_W:0]    ptr_inc;
   logic [PTR_W-1:0]  ptr_wrap;
   logic [HASH_W:0]   final_sum;
   logic [HASH_W:0]   final_less_p;
   logic [HASH_W-1:0] hash_new;
   logic [HASH_W:0]   diff_direct;
   logic [HASH_W:0]   diff_wrap;
   logic [HASH_W-1:0] diff;
   logic              rsp_free;
   logic              ram_we;
   logic [HASH_W-1:0] ram_rdata;

   mm_cmd_type        mm_cmd;
   mm_sts_type        mm_sts;

   rwph_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mm_cmd),
      .modulus (p_eff),
      .sts     (mm_sts)
   );

   rwph_ram #(
      .WIDTH (HASH_W),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_pos),
      .wr_data (resid_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      p_eff = (modulus_ff < MODULUS_MIN) ? MODULUS_MIN : modulus_ff;
      if (wlen_ff == '0) begin
         len_eff = FILL_W'(1);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         len_eff = FILL_W'(MAX_WINDOW);
      end else begin
         len_eff = FILL_W'(wlen_ff);
      end

      fill_cur  = req_bus.restart ? '0 : fill_ff;
      fill_next = fill_ff + FILL_W'(1);

      pos_sum  = POS_W'(ptr_ff) + POS_W'(fill_ff);
      pos_wrap = (pos_sum >= POS_W'(MAX_WINDOW)) ? pos_sum - POS_W'(MAX_WINDOW) : pos_sum;
      wr_pos   = pos_wrap[PTR_W-1:0];
      ptr_inc  = {1'b0, ptr_ff} + (PTR_W+1)'(1);
      ptr_wrap = (ptr_inc == (PTR_W+1)'(MAX_WINDOW)) ? '0 : ptr_inc[PTR_W-1:0];

      final_sum    = {1'b0, prod_ff} + {1'b0, resid_ff};
      final_less_p = final_sum - {1'b0, p_eff};
      hash_new     = (final_sum >= {1'b0, p_eff}) ? final_less_p[HASH_W-1:0]
                                                  : final_sum[HASH_W-1:0];

      diff_direct = {1'b0, mm_sts.result} - {1'b0, term_ff};
      diff_wrap   = {1'b0, mm_sts.result} + {1'b0, p_eff} - {1'b0, term_ff};
      diff        = (mm_sts.result >= term_ff) ? diff_direct[HASH_W-1:0]
                                               : diff_wrap[HASH_W-1:0];

      rsp_free = !rsp_valid_ff || rsp_bus.ready;
   end

   always_comb begin
      mm_cmd.start        = (state_ff == ST_ISSUE);
      mm_cmd.multiplicand = ONE;
      mm_cmd.digits       = sym_ff;
      mm_cmd.steps        = STEPS_WORD;
      case (phase_ff)
         PH_SYMBOL: begin
            if (byte_mode_ff) begin
               mm_cmd.digits = {sym_ff[7:0] ^ BYTE_OFFSET, {(SYM_W-8){1'b0}}};
               mm_cmd.steps  = STEPS_BYTE;
            end
         end
         PH_LEAD_RED: begin
            mm_cmd.digits = {lead_ff, {(SYM_W-HASH_W){1'b0}}};
            if (lead_ff < p_eff) begin
               mm_cmd.multiplicand = lead_ff;
               mm_cmd.steps        = STEPS_NONE;
            end else begin
               mm_cmd.steps = STEPS_RESIDUE;
            end
         end
         PH_LEAD_MUL, PH_HASH_MUL: begin
            mm_cmd.multiplicand = opa_ff;
            mm_cmd.digits       = {base_ff, {(SYM_W-HASH_W){1'b0}}};
            mm_cmd.steps        = STEPS_RESIDUE;
         end
         PH_TERM: begin
            mm_cmd.multiplicand = opa_ff;
            mm_cmd.digits       = {ram_rdata, {(SYM_W-HASH_W){1'b0}}};
            mm_cmd.steps        = STEPS_RESIDUE;
         end
         PH_HASH_RED: begin
            mm_cmd.digits = {hash_ff, {(SYM_W-HASH_W){1'b0}}};
            if (hash_ff < p_eff) begin
               mm_cmd.multiplicand = hash_ff;
               mm_cmd.steps        = STEPS_NONE;
            end else begin
               mm_cmd.steps = STEPS_RESIDUE;
            end
         end
         default: begin
            mm_cmd.steps = STEPS_WORD;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      modulus_in   = modulus_ff;
      base_in      = base_ff;
      wlen_in      = wlen_ff;
      byte_mode_in = byte_mode_ff;
      hash_in      = hash_ff;
      lead_in      = lead_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      roll_in      = roll_ff;
      sym_in       = sym_ff;
      resid_in     = resid_ff;
      opa_in       = opa_ff;
      term_in      = term_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_full_in  = rsp_full_ff;
      ram_we       = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_MODULUS:       modulus_in   = csr_wdata[HASH_W-1:0];
            REG_BASE:          base_in      = csr_wdata[HASH_W-1:0];
            REG_WINDOW_LENGTH: wlen_in      = csr_wdata[LEN_W-1:0];
            REG_BYTE_MODE:     byte_mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               sym_in   = req_bus.symbol;
               roll_in  = (fill_cur >= len_eff);
               phase_in = PH_SYMBOL;
               state_in = ST_ISSUE;
               if (req_bus.restart) begin
                  fill_in = '0;
                  ptr_in  = '0;
                  hash_in = '0;
                  lead_in = ONE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mm_sts.done) begin
               state_in = ST_ISSUE;
               case (phase_ff)
                  PH_SYMBOL: begin
                     resid_in = mm_sts.result;
                     if (!roll_ff && fill_ff == '0) begin
                        lead_in  = ONE;
                        phase_in = PH_HASH_RED;
                     end else begin
                        phase_in = PH_LEAD_RED;
                     end
                  end
                  PH_LEAD_RED: begin
                     opa_in   = mm_sts.result;
                     phase_in = roll_ff ? PH_TERM : PH_LEAD_MUL;
                  end
                  PH_LEAD_MUL: begin
                     lead_in  = mm_sts.result;
                     phase_in = PH_HASH_RED;
                  end
                  PH_TERM: begin
                     term_in  = mm_sts.result;
                     phase_in = PH_HASH_RED;
                  end
                  PH_HASH_RED: begin
                     opa_in   = roll_ff ? diff : mm_sts.result;
                     phase_in = PH_HASH_MUL;
                  end
                  PH_HASH_MUL: begin
                     prod_in  = mm_sts.result;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               hash_in      = hash_new;
               ram_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_new;
               if (roll_ff) begin
                  ptr_in      = ptr_wrap;
                  rsp_full_in = 1'b1;
               end else begin
                  fill_in     = fill_next;
                  rsp_full_in = (fill_next >= len_eff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SYMBOL;
         modulus_ff   <= MODULUS_RESET;
         base_ff      <= BASE_RESET;
         wlen_ff      <= LENGTH_RESET;
         byte_mode_ff <= 1'b0;
         hash_ff      <= '0;
         lead_ff      <= ONE;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         roll_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         modulus_ff   <= modulus_in;
         base_ff      <= base_in;
         wlen_ff      <= wlen_in;
         byte_mode_ff <= byte_mode_in;
         hash_ff      <= hash_in;
         lead_ff      <= lead_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         roll_ff      <= roll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff      <= sym_in;
      resid_ff    <= resid_in;
      opa_ff      <= opa_in;
      term_ff     <= term_in;
      prod_ff     <= prod_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hash_value  = rsp_hash_ff;
   assign rsp_bus.window_full = rsp_full_ff;

`ifndef SYNTH
   a_hash_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> (rsp_hash_ff < $past(p_eff)))
      else $error("hash beat not reduced below modulus");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (32'(fill_ff) <= MAX_WINDOW))
      else $error("fill count beyond window store depth");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_ISSUE && phase_ff == PH_SYMBOL))
      else $error("accepted beat did not start the symbol reduction");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mm_sts.done |-> (state_ff == ST_WAIT))
      else $error("multiply unit finished outside a wait state");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_rolling_window_polynomial_hash.sv */
// Testbench for the rolling window hash: directed and random symbols checked against a predictor.
`timescale 1ns / 1ps

module tb_rolling_window_polynomial_hash;
   import rwph_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int RESET_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 1000;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 85;
   localparam int PRESSURE_ITEMS  = 12;

   localparam logic [HASH_W-1:0] MODULUS_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic              window_full;
   } hash_beat_t;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [REG_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   rwph_req_if req_bus ();
   rwph_rsp_if rsp_bus ();

   rolling_window_polynomial_hash dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [HASH_W-1:0] cfg_modulus;
   logic [HASH_W-1:0] cfg_base;
   logic [LEN_W-1:0]  cfg_window_length;
   logic              cfg_byte_mode;

   logic [HASH_W-1:0] win_residues [MAX_WINDOW];
   logic [HASH_W-1:0] win_hash;
   logic [HASH_W-1:0] win_lead_power;
   logic [FILL_W-1:0] win_fill;
   logic [PTR_W-1:0]  win_oldest;

   hash_beat_t  expected_hashes [$];
   int unsigned mismatch_count = 0;
   int unsigned symbols_sent   = 0;
   int unsigned hashes_checked = 0;
   int unsigned full_hashes    = 0;
   int unsigned settings_count = 0;
   int unsigned stalled_cycles = 0;
   bit          tx_idle;
   bit          rx_idle;
   bit          rx_hold_request;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned idle_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                               longint unsigned p);
      return ((a % p) * (b % p)) % p;
   endfunction

   function automatic hash_beat_t roll_hash(logic [SYM_W-1:0] sym, logic restart);
      longint unsigned p;
      longint unsigned len;
      longint unsigned b;
      longint unsigned v;
      longint unsigned h;
      longint unsigned term;
      logic [PTR_W-1:0] pos;
      hash_beat_t       beat;
      p = (cfg_modulus < MODULUS_MIN) ? 2 : cfg_modulus;
      if (cfg_window_length == 0) len = 1;
      else if (cfg_window_length > MAX_WINDOW) len = MAX_WINDOW;
      else len = cfg_window_length;
      b = cfg_base % p;
      if (cfg_byte_mode) v = 64'(sym[7:0] ^ BYTE_OFFSET) % p;
      else v = sym % p;
      if (restart) begin
         win_fill       = '0;
         win_oldest     = '0;
         win_hash       = '0;
         win_lead_power = ONE;
      end
      pos = win_oldest + PTR_W'(win_fill);
      if (win_fill < len) begin
         win_lead_power = (win_fill == 0) ? ONE : HASH_W'(mul_mod(win_lead_power, b, p));
         win_hash       = HASH_W'((mul_mod(win_hash, b, p) + v) % p);
         win_fill++;
      end else begin
         // drop the oldest term, then shift in the new symbol
         term       = mul_mod(win_lead_power, win_residues[win_oldest], p);
         h          = (win_hash % p + p - term) % p;
         win_hash   = HASH_W'((mul_mod(h, b, p) + v) % p);
         win_oldest++;
      end
      win_residues[pos] = HASH_W'(v);
      beat.hash_value   = win_hash;
      beat.window_full  = (win_fill >= len);
      return beat;
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol();
      logic [SYM_W-1:0] p;
      p = (cfg_modulus < MODULUS_MIN) ? 2 : cfg_modulus;
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 300);
         1: return p - 1 + $urandom_range(0, 2);
         2: return $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_symbol(logic [SYM_W-1:0] sym, logic restart);
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle_gap()) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.symbol  <= sym;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
      expected_hashes.push_back(roll_hash(sym, restart));
      symbols_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(logic [CSR_W-1:0] mod_value, logic [CSR_W-1:0] base_value,
                                logic [LEN_W-1:0] length_value, logic byte_value);
      csr_wr_en <= 1'b1;
      csr_index <= REG_MODULUS;
      csr_wdata <= mod_value;
      @(posedge clock);
      csr_index <= REG_BASE;
      csr_wdata <= base_value;
      @(posedge clock);
      csr_index <= REG_WINDOW_LENGTH;
      csr_wdata <= CSR_W'(length_value);
      @(posedge clock);
      csr_index <= REG_BYTE_MODE;
      csr_wdata <= CSR_W'(byte_value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_modulus       = mod_value;
      cfg_base          = base_value;
      cfg_window_length = length_value;
      cfg_byte_mode     = byte_value;
      settings_count++;
   endtask

   task automatic run_phase(int unsigned count);
      for (int i = 0; i < count; i++)
         send_symbol(pick_symbol(),
                     (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0));
   endtask

   task automatic test_fill_and_roll_defaults();
      logic [SYM_W-1:0] corners [6];
      corners = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFE,
                  64'h8000_0000_0000_0000, 64'hAAAA_5555_AAAA_5555};
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      for (int i = 0; i < 18; i++) send_symbol(corners[i % 6], 1'b0);
      send_symbol(64'h0000_0000_8000_0001, 1'b1);
   endtask

   task automatic test_byte_mode_edges();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      wait_drained();
      set_registers(31'd251, 31'd1000, 7'd3, 1'b1);
      send_symbol(64'h00, 1'b1);
      send_symbol(64'h7F, 1'b0);
      send_symbol(64'h80, 1'b0);
      send_symbol(64'hFF, 1'b0);
      send_symbol(64'hFFFF_FFFF_FFFF_FF01, 1'b1);
      send_symbol(64'h80, 1'b0);
   endtask

   task automatic test_register_edges();
      wait_drained();
      set_registers('0, '0, '0, 1'b0);
      send_symbol(64'h3, 1'b0);
      send_symbol(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      wait_drained();
      set_registers(31'd1, 31'd5, 7'd127, 1'b0);
      send_symbol(64'h5, 1'b0);
      send_symbol(64'h6, 1'b0);
   endtask

   task automatic test_backpressure();
      wait_drained();
      tx_idle         = 1'b0;
      rx_hold_request = 1'b1;
      run_phase(PRESSURE_ITEMS);
      wait_drained();
   endtask

   task automatic test_random_settings();
      logic [CSR_W-1:0] mod_value;
      logic [CSR_W-1:0] base_value;
      logic [LEN_W-1:0] length_value;
      logic             byte_value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: mod_value = MODULUS_MAX;
            1: mod_value = MODULUS_MIN;
            2: mod_value = $urandom_range(0, 1);
            3: mod_value = 31'd65521;
            default: mod_value = $urandom_range(2, MODULUS_MAX);
         endcase
         case ($urandom_range(0, 5))
            0: base_value = ONE;
            1: base_value = MODULUS_MAX;
            2: base_value = '0;
            3: base_value = mod_value + $urandom_range(0, 1000);
            default: base_value = CSR_W'($urandom);
         endcase
         case ($urandom_range(0, 6))
            0: length_value = 7'd1;
            1: length_value = LEN_W'(MAX_WINDOW);
            2: length_value = '0;
            3: length_value = $urandom_range(MAX_WINDOW + 1, 127);
            4: length_value = $urandom_range(2, 8);
            default: length_value = $urandom_range(1, MAX_WINDOW);
         endcase
         byte_value = $urandom_range(0, 1);
         if (phase == 0) begin
            mod_value    = MODULUS_MIN;
            base_value   = MODULUS_MAX;
            length_value = LEN_W'(MAX_WINDOW);
            byte_value   = 1'b0;
         end else if (phase == 1) begin
            mod_value    = MODULUS_MAX;
            base_value   = MODULUS_MAX - 1;
            length_value = 7'd1;
            byte_value   = 1'b1;
         end
         tx_idle = (phase % 3 != 0);
         rx_idle = (phase % 4 != 1);
         wait_drained();
         set_registers(mod_value, base_value, length_value, byte_value);
         run_phase(PHASE_ITEMS);
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_gap()) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      hash_beat_t want_beat;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_hashes.size() == 0) begin
            $error("unexpected result beat: hash_value %h window_full %b",
                   rsp_bus.hash_value, rsp_bus.window_full);
            mismatch_count++;
         end else begin
            want_beat = expected_hashes.pop_front();
            if (rsp_bus.hash_value !== want_beat.hash_value) begin
               $error("hash_value mismatch: expected %h, actual %h",
                      want_beat.hash_value, rsp_bus.hash_value);
               mismatch_count++;
            end
            if (rsp_bus.window_full !== want_beat.window_full) begin
               $error("window_full mismatch: expected %b, actual %b",
                      want_beat.window_full, rsp_bus.window_full);
               mismatch_count++;
            end
            if (rsp_bus.window_full) full_hashes++;
            hashes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_index       <= REG_MODULUS;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.symbol  <= '0;
      req_bus.restart <= 1'b0;
      tx_idle           = 1'b0;
      rx_idle           = 1'b0;
      rx_hold_request   = 1'b0;
      cfg_modulus       = MODULUS_RESET;
      cfg_base          = BASE_RESET;
      cfg_window_length = LENGTH_RESET;
      cfg_byte_mode     = 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) win_residues[i] = '0;
      win_hash       = '0;
      win_lead_power = ONE;
      win_fill       = '0;
      win_oldest     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_fill_and_roll_defaults();
      test_byte_mode_edges();
      test_register_edges();
      test_backpressure();
      test_random_settings();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Hashed %0d symbols under %0d register settings after the reset values.",
               symbols_sent, settings_count);
      $display("Checked %0d hash beats, %0d of them over a full rolling window.",
               hashes_checked, full_hashes);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* rolling_window_polynomial_hash.f */
rtl/core/rwph_pkg.sv
rtl/core/rwph_req_if.sv
rtl/core/rwph_rsp_if.sv
rtl/core/rwph_ram.sv
rtl/core/rwph_modmul.sv
rtl/core/rolling_window_polynomial_hash.sv
tb/sv/tb_rolling_window_polynomial_hash.sv
